/* rtl/core/qlrs_pkg.sv */
// ----------------------------------------------------------------------------
// qlrs_pkg
// Shared types and constants for the quadrature LED ring stepper.
// ----------------------------------------------------------------------------
package qlrs_pkg;

    // Ring geometry
    localparam int LED_COUNT = 16;
    localparam int POS_W     = $clog2(LED_COUNT);
    localparam int LED_W     = 16;

    // Blink timing
    localparam int BLINK_W   = 24;
    localparam int BCNT_W    = 25;
    localparam logic [BLINK_W-1:0] BLINK_RESET = BLINK_W'(500000);

    // Encoder pin codes
    localparam logic [1:0] PINS_00 = 2'b00;
    localparam logic [1:0] PINS_01 = 2'b01;
    localparam logic [1:0] PINS_10 = 2'b10;
    localparam logic [1:0] PINS_11 = 2'b11;

    typedef enum logic [2:0] {
        DEC_IDLE = 3'd0,   // pins 11
        DEC_CW1  = 3'd1,   // pins 01, clockwise
        DEC_CCW1 = 3'd2,   // pins 10, counter-clockwise
        DEC_CW2  = 3'd3,   // pins 00, clockwise
        DEC_CCW2 = 3'd4,   // pins 00, counter-clockwise
        DEC_CW3  = 3'd5,   // pins 10, clockwise
        DEC_CCW3 = 3'd6    // pins 01, counter-clockwise
    } t_dec_state;

    typedef struct packed {
        logic [1:0] encoder_pins;
        logic       led_enable;
    } t_qlrs_in;

    typedef struct packed {
        logic [LED_W-1:0] led_pattern;
        logic             green_led;
        logic             step_cw;
        logic             step_ccw;
    } t_qlrs_out;

endpackage

/* rtl/core/quadrature_led_ring_stepper.sv */
// ----------------------------------------------------------------------------
// quadrature_led_ring_stepper
// Quadrature detent decoder driving a one-hot LED ring, plus a blink counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one sample of
//   the two encoder pins and the LED enable per beat. Every accepted beat
//   produces exactly one result beat on the output channel
//   (o_out_valid / i_out_ready / o_out_data): LED pattern, green LED level
//   and the clockwise / counter-clockwise detent flags.
//   The result of a beat accepted at a clock edge is registered and valid
//   after that edge. Throughput is one sample per cycle while the receiver
//   takes results; the single output register is reloaded in the same
//   cycle it is drained. When the receiver stalls, the result register
//   holds and o_in_ready drops until the held result is taken.
//   The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   the blink half period; it is always ready and should be written only
//   while no sample is in flight.
//   Synchronous reset puts the decoder in idle (both pins high), the ring
//   position at the last LED, clears the pattern and the blink counter, and
//   loads the half period with 500000.
// ----------------------------------------------------------------------------
module quadrature_led_ring_stepper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  qlrs_pkg::t_qlrs_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output qlrs_pkg::t_qlrs_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qlrs_pkg::BLINK_W-1:0]        i_cfg_data
);

    localparam logic [qlrs_pkg::POS_W-1:0] POS_MAX =
        qlrs_pkg::POS_W'(qlrs_pkg::LED_COUNT - 1);

    qlrs_pkg::t_dec_state                r_state, n_state;
    logic [qlrs_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [qlrs_pkg::LED_W-1:0]          r_pattern, n_pattern;
    logic [qlrs_pkg::BCNT_W-1:0]         r_bcnt, n_bcnt;
    logic [qlrs_pkg::BLINK_W-1:0]        r_half;
    logic                                r_out_valid;
    qlrs_pkg::t_qlrs_out                 r_out, n_out;

    logic                                w_in_fire;
    logic                                w_cw;
    logic                                w_ccw;
    logic                                w_green;
    logic [qlrs_pkg::BCNT_W-1:0]         w_bcnt_inc;
    logic [qlrs_pkg::LED_W-1:0]          w_show;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // One-hot at the current position; positions past the field width vanish
    assign w_show = qlrs_pkg::LED_W'(1) << r_pos;

    // Decoder: next state and detent flags
    always_comb begin
        n_state = r_state;
        w_cw    = 1'b0;
        w_ccw   = 1'b0;
        unique case (r_state)
            qlrs_pkg::DEC_IDLE: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_01) begin
                    n_state = qlrs_pkg::DEC_CW1;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_10) begin
                    n_state = qlrs_pkg::DEC_CCW1;
                end
            end
            qlrs_pkg::DEC_CW1: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_00) begin
                    n_state = qlrs_pkg::DEC_CW2;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_11) begin
                    n_state = qlrs_pkg::DEC_IDLE;
                end
            end
            qlrs_pkg::DEC_CCW1: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_00) begin
                    n_state = qlrs_pkg::DEC_CCW2;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_11) begin
                    n_state = qlrs_pkg::DEC_IDLE;
                end
            end
            qlrs_pkg::DEC_CW2: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_10) begin
                    n_state = qlrs_pkg::DEC_CW3;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_01) begin
                    n_state = qlrs_pkg::DEC_CW1;
                end
            end
            qlrs_pkg::DEC_CCW2: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_01) begin
                    n_state = qlrs_pkg::DEC_CCW3;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_10) begin
                    n_state = qlrs_pkg::DEC_CCW1;
                end
            end
            qlrs_pkg::DEC_CW3: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_00) begin
                    n_state = qlrs_pkg::DEC_CW2;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_11) begin
                    n_state = qlrs_pkg::DEC_IDLE;
                    w_cw    = 1'b1;
                end
            end
            qlrs_pkg::DEC_CCW3: begin
                if (i_in_data.encoder_pins == qlrs_pkg::PINS_00) begin
                    n_state = qlrs_pkg::DEC_CCW2;
                end else if (i_in_data.encoder_pins == qlrs_pkg::PINS_11) begin
                    n_state = qlrs_pkg::DEC_IDLE;
                    w_ccw   = 1'b1;
                end
            end
            default: begin
                n_state = qlrs_pkg::DEC_IDLE;
            end
        endcase
    end

    // Ring position, pattern, blink counter and the result beat
    always_comb begin
        n_pos     = r_pos;
        n_pattern = r_pattern;
        if (!i_in_data.led_enable) begin
            n_pattern = '0;
        end else if (w_cw) begin
            n_pattern = w_show;
            n_pos     = (r_pos == '0) ? POS_MAX : r_pos - 1'b1;
        end else if (w_ccw) begin
            n_pattern = w_show;
            n_pos     = (r_pos == POS_MAX) ? '0 : r_pos + 1'b1;
        end

        // Green is judged on the counter before this sample
        w_green    = r_bcnt < qlrs_pkg::BCNT_W'(r_half);
        w_bcnt_inc = r_bcnt + 1'b1;
        n_bcnt     = (w_bcnt_inc > {r_half, 1'b0}) ? '0 : w_bcnt_inc;

        n_out.led_pattern = n_pattern;
        n_out.green_led   = w_green;
        n_out.step_cw     = w_cw;
        n_out.step_ccw    = w_ccw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qlrs_pkg::DEC_IDLE;
            r_pos       <= POS_MAX;
            r_pattern   <= '0;
            r_bcnt      <= '0;
            r_half      <= qlrs_pkg::BLINK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_half <= i_cfg_data;
            end
            if (w_in_fire) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_pattern   <= n_pattern;
                r_bcnt      <= n_bcnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

    // A detent is either clockwise or counter-clockwise, never both
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.step_cw && o_out_data.step_ccw))
        else $error("both detent directions flagged in one result");

    // Pattern is cleared or shows exactly one LED
    a_pattern_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_data.led_pattern))
        else $error("LED pattern has more than one LED lit");

    // Position moves only on an accepted beat
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_fire |=> $stable(r_pos))
        else $error("ring position moved without an accepted sample");

    // A moved position means a detent with the enable set was reported
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && n_pos != r_pos) |=>
            (o_out_data.step_cw || o_out_data.step_ccw))
        else $error("ring position moved without a detent");

endmodule

/* tb/ring_stepper_checker.sv */
// ----------------------------------------------------------------------------
// ring_stepper_checker
// Watches the sample, result and blink-period channels of the quadrature LED
// ring stepper. Keeps its own copy of the decoder, ring position, LED pattern
// and blink counter. Queues the expected result of every sample beat and
// compares each result beat with the oldest one, field by field.
// ----------------------------------------------------------------------------
module ring_stepper_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  qlrs_pkg::t_qlrs_in            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  qlrs_pkg::t_qlrs_out           i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [qlrs_pkg::BLINK_W-1:0]  i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_detents
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [qlrs_pkg::POS_W-1:0] POS_LAST =
        qlrs_pkg::POS_W'(qlrs_pkg::LED_COUNT - 1);

    qlrs_pkg::t_dec_state                 dec_state;
    logic [qlrs_pkg::POS_W-1:0]           ring_pos;
    logic [31:0]                          lit_leds;
    logic [qlrs_pkg::BCNT_W-1:0]          blink_cnt;
    logic [qlrs_pkg::BLINK_W-1:0]         half_period;
    qlrs_pkg::t_qlrs_out                  expected_results[$];

    function automatic qlrs_pkg::t_qlrs_out predict_sample(input qlrs_pkg::t_qlrs_in sample);
        qlrs_pkg::t_qlrs_out  res;
        qlrs_pkg::t_dec_state nxt;
        logic                 cw;
        logic                 ccw;
        cw  = 1'b0;
        ccw = 1'b0;
        nxt = dec_state;
        if (!sample.led_enable) lit_leds = '0;
        case (dec_state)
            qlrs_pkg::DEC_IDLE: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_01) nxt = qlrs_pkg::DEC_CW1;
                else if (sample.encoder_pins == qlrs_pkg::PINS_10) nxt = qlrs_pkg::DEC_CCW1;
            end
            qlrs_pkg::DEC_CW1: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_00) nxt = qlrs_pkg::DEC_CW2;
                else if (sample.encoder_pins == qlrs_pkg::PINS_11) nxt = qlrs_pkg::DEC_IDLE;
            end
            qlrs_pkg::DEC_CCW1: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_00) nxt = qlrs_pkg::DEC_CCW2;
                else if (sample.encoder_pins == qlrs_pkg::PINS_11) nxt = qlrs_pkg::DEC_IDLE;
            end
            qlrs_pkg::DEC_CW2: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_10) nxt = qlrs_pkg::DEC_CW3;
                else if (sample.encoder_pins == qlrs_pkg::PINS_01) nxt = qlrs_pkg::DEC_CW1;
            end
            qlrs_pkg::DEC_CCW2: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_01) nxt = qlrs_pkg::DEC_CCW3;
                else if (sample.encoder_pins == qlrs_pkg::PINS_10) nxt = qlrs_pkg::DEC_CCW1;
            end
            qlrs_pkg::DEC_CW3: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_00) nxt = qlrs_pkg::DEC_CW2;
                else if (sample.encoder_pins == qlrs_pkg::PINS_11) begin
                    cw  = 1'b1;
                    nxt = qlrs_pkg::DEC_IDLE;
                end
            end
            qlrs_pkg::DEC_CCW3: begin
                if (sample.encoder_pins == qlrs_pkg::PINS_00) nxt = qlrs_pkg::DEC_CCW2;
                else if (sample.encoder_pins == qlrs_pkg::PINS_11) begin
                    ccw = 1'b1;
                    nxt = qlrs_pkg::DEC_IDLE;
                end
            end
            default: nxt = qlrs_pkg::DEC_IDLE;
        endcase
        // a detent with the enable low is flagged but moves nothing
        if (sample.led_enable && (cw || ccw)) begin
            lit_leds = 32'd1 << ring_pos;
            if (cw)
                ring_pos = (ring_pos == '0) ? POS_LAST : ring_pos - 1'b1;
            else
                ring_pos = (ring_pos == POS_LAST) ? '0 : ring_pos + 1'b1;
        end
        dec_state = nxt;

        res.green_led = (blink_cnt < qlrs_pkg::BCNT_W'(half_period));
        blink_cnt = blink_cnt + 1'b1;
        // drop back to zero once past the full period, also after a lowered period
        if (blink_cnt > {half_period, 1'b0}) blink_cnt = '0;

        res.led_pattern = lit_leds[qlrs_pkg::LED_W-1:0];
        res.step_cw     = cw;
        res.step_ccw    = ccw;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        qlrs_pkg::t_qlrs_out want;
        if (!i_rst_n) begin
            dec_state   = qlrs_pkg::DEC_IDLE;
            ring_pos    = POS_LAST;
            lit_leds    = '0;
            blink_cnt   = '0;
            half_period = qlrs_pkg::BLINK_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) half_period = i_cfg_data;
            // retire before queueing: a beat never answers itself in the same cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing expected, expected none, got 0x%0h",
                             $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("led_pattern", 32'(want.led_pattern),
                                32'(i_out_data.led_pattern));
                    check_field("green_led", 32'(want.green_led),
                                32'(i_out_data.green_led));
                    check_field("step_cw", 32'(want.step_cw),
                                32'(i_out_data.step_cw));
                    check_field("step_ccw", 32'(want.step_ccw),
                                32'(i_out_data.step_ccw));
                end
                if (i_out_data.step_cw || i_out_data.step_ccw) o_detents++;
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_sample(i_in_data));
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quadrature LED ring stepper. Drives a directed
// walk through both detent directions, wrap-around, bounces and disabled
// detents, then a biased random walk of the encoder over several blink half
// periods, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_SAMPLES  = 196;
    localparam int STEADY_SAMPLES = 40;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    // directed walk: bounces on the clockwise path, one clockwise detent,
    // two counter-clockwise detents (the second wraps to 0), a disabled
    // clockwise detent, then a clockwise detent from position 0
    localparam logic [2*NUM_DIRECTED-1:0] DIRECTED_PINS = {
        qlrs_pkg::PINS_11, qlrs_pkg::PINS_00, qlrs_pkg::PINS_01, qlrs_pkg::PINS_01,
        qlrs_pkg::PINS_00, qlrs_pkg::PINS_10, qlrs_pkg::PINS_00, qlrs_pkg::PINS_10,
        qlrs_pkg::PINS_11,
        qlrs_pkg::PINS_10, qlrs_pkg::PINS_00, qlrs_pkg::PINS_01, qlrs_pkg::PINS_11,
        qlrs_pkg::PINS_10, qlrs_pkg::PINS_00, qlrs_pkg::PINS_01, qlrs_pkg::PINS_11,
        qlrs_pkg::PINS_01, qlrs_pkg::PINS_00, qlrs_pkg::PINS_10, qlrs_pkg::PINS_11,
        qlrs_pkg::PINS_01, qlrs_pkg::PINS_00, qlrs_pkg::PINS_10, qlrs_pkg::PINS_11
    };
    localparam logic [NUM_DIRECTED-1:0] DIRECTED_EN = {17'h1FFFF, 4'h0, 4'hF};

    localparam logic [NUM_PHASES*qlrs_pkg::BLINK_W-1:0] HALF_STEPS = {
        24'd100, 24'd3, 24'd1, 24'd16777215, 24'd2, 24'd9, 24'd64
    };

    // one clockwise turn of the pins, in order
    localparam logic [7:0] CW_CYCLE = {
        qlrs_pkg::PINS_11, qlrs_pkg::PINS_01, qlrs_pkg::PINS_00, qlrs_pkg::PINS_10
    };

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    qlrs_pkg::t_qlrs_in            i_in_data   = '0;
    logic                          i_out_ready = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [qlrs_pkg::BLINK_W-1:0]  i_cfg_data  = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    qlrs_pkg::t_qlrs_out           o_out_data;
    logic                          o_cfg_ready;

    int                  fail_count;
    int                  results_pending;
    int                  detents_seen;
    int                  samples_sent  = 0;
    int                  settings_used = 1;
    int                  quiet_cycles  = 0;
    bit                  idle_on       = 1'b1;
    bit                  sender_steady = 1'b0;
    bit                  long_hold_req = 1'b0;
    bit                  turn_cw       = 1'b1;
    logic [1:0]          quad_idx      = 2'd0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    quadrature_led_ring_stepper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    ring_stepper_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_detents    (detents_seen)
    );

    task automatic push_sample(input qlrs_pkg::t_qlrs_in item);
        if (idle_on && !sender_steady && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        samples_sent++;
    endtask

    // biased walk around the pin cycle: mostly forward, some bounce and backing
    // off, a few glitches, and a direction change now and then at rest
    task automatic next_turn(output qlrs_pkg::t_qlrs_in item);
        int roll;
        roll = $urandom_range(0, 99);
        item.led_enable = ($urandom_range(0, 9) != 0);
        if (roll < 4) begin
            item.encoder_pins = 2'($urandom_range(0, 3));
        end else begin
            if (roll >= 16)
                quad_idx = turn_cw ? quad_idx + 2'd1 : quad_idx - 2'd1;
            else if (roll >= 10)
                quad_idx = turn_cw ? quad_idx - 2'd1 : quad_idx + 2'd1;
            item.encoder_pins = CW_CYCLE[2*(3 - quad_idx) +: 2];
            if (quad_idx == 2'd0 && $urandom_range(0, 3) == 0) turn_cw = !turn_cw;
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_half_period(input logic [qlrs_pkg::BLINK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat on any channel for %0d cycles", $time, quiet_cycles);
            $display("FAIL quadrature_led_ring_stepper");
            $finish;
        end
    end

    initial begin
        qlrs_pkg::t_qlrs_in item;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            item.encoder_pins = DIRECTED_PINS[2*(NUM_DIRECTED - 1 - k) +: 2];
            item.led_enable   = DIRECTED_EN[NUM_DIRECTED - 1 - k];
            push_sample(item);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_results_drained();
            repeat (2) @(posedge i_clk);
            write_half_period(
                HALF_STEPS[qlrs_pkg::BLINK_W*(NUM_PHASES - 1 - ph) +: qlrs_pkg::BLINK_W]);
            if (ph == 2) begin
                // stall results while samples keep coming
                long_hold_req = 1'b1;
                sender_steady = 1'b1;
            end
            if (ph == NUM_PHASES - 1) idle_on = 1'b0;
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if (n == STEADY_SAMPLES) sender_steady = 1'b0;
                next_turn(item);
                push_sample(item);
            end
        end

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        $display("Sent %0d encoder samples over %0d blink half periods, %0d detents flagged.",
                 samples_sent, settings_used, detents_seen);
        if (fail_count == 0 && results_pending == 0) begin
            $display("PASS quadrature_led_ring_stepper");
        end else begin
            $display("FAIL quadrature_led_ring_stepper");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/qlrs_pkg.sv
rtl/core/quadrature_led_ring_stepper.sv
tb/ring_stepper_checker.sv
tb/tb.sv
